### hw/rtl/mtbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtbd_pkg
// Shared types, constants and the tempering function of the bounded
// draw twister.
// ----------------------------------------------------------------------------
package mtbd_pkg;

	localparam int unsigned ADDR_W      = 10;
	localparam int unsigned IDX_W       = 10;
	localparam int unsigned LIMIT_W     = 16;
	localparam int unsigned WORD_W      = 32;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [IDX_W-1:0] WORDS    = 10'd624;
	localparam logic [IDX_W-1:0] SHIFT_M  = 10'd397;
	localparam logic [IDX_W-1:0] WRAP_M   = WORDS - SHIFT_M;
	localparam logic [IDX_W-1:0] LAST     = WORDS - 10'd1;
	localparam logic [IDX_W-1:0] UNSEEDED = 10'd625;

	localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'd4357;
	localparam logic [WORD_W-1:0] SEED_MULT    = 32'd69069;
	localparam logic [WORD_W-1:0] TWIST_A      = 32'h9908b0df;
	localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c5680;
	localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc60000;

	localparam logic [1:0] KIND_SEED = 2'd0;
	localparam logic [1:0] KIND_DRAW = 2'd1;
	localparam logic [1:0] KIND_ZERO = 2'd2;

	typedef struct packed {
		logic [1:0]         kind;
		logic [WORD_W-1:0]  seed;
		logic [LIMIT_W-1:0] limit;
		logic [LIMIT_W-1:0] mask;
	} mtbd_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} mtbd_qstat_t;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
	} mtbd_estat_t;

	function automatic logic [WORD_W-1:0] mtbd_temper(input logic [WORD_W-1:0] w);
		logic [WORD_W-1:0] y;
		y = w ^ (w >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage

### hw/rtl/mtbd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtbd_front
// Input side: takes items, sorts them into seed, draw and zero-limit
// commands and works out the draw mask from the bit length of the limit.
// ----------------------------------------------------------------------------
module mtbd_front (
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [47:0]            s_tdata,   // seed_value[31:0], upper_limit[47:32]
	input  logic                   s_tuser,   // func
	input  mtbd_pkg::mtbd_qstat_t  qstat,
	output logic                   push,
	output mtbd_pkg::mtbd_cmd_t    cmd
);
	import mtbd_pkg::*;

	logic [LIMIT_W-1:0] limit;
	logic [LIMIT_W-1:0] smear;

	always_comb begin
		limit = s_tdata[47:32];
		smear = limit | (limit >> 1);
		smear = smear | (smear >> 2);
		smear = smear | (smear >> 4);
		smear = smear | (smear >> 8);

		cmd.seed  = s_tdata[31:0];
		cmd.limit = limit;
		cmd.mask  = smear;
		if (!s_tuser) begin
			cmd.kind = KIND_SEED;
		end else if (limit == '0) begin
			cmd.kind = KIND_ZERO;
		end else begin
			cmd.kind = KIND_DRAW;
		end
	end

	assign s_tready = !qstat.full;
	assign push     = s_tvalid && !qstat.full;

endmodule

### hw/rtl/mtbd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtbd_queue
// Short command queue between the front and the generator engine.
// ----------------------------------------------------------------------------
module mtbd_queue #(
	parameter int unsigned DEPTH = mtbd_pkg::QUEUE_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  mtbd_pkg::mtbd_cmd_t    push_cmd,
	input  logic                   pop,
	output mtbd_pkg::mtbd_cmd_t    head_cmd,
	output mtbd_pkg::mtbd_qstat_t  qstat
);
	import mtbd_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	mtbd_cmd_t         slot_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign qstat.full  = (count_q == CNT_FULL);
	assign qstat.empty = (count_q == '0);
	assign head_cmd    = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### hw/rtl/mtbd_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtbd_engine
// Back end: word memory, seeding sequencer, one-word-at-a-time twist,
// tempering, masking and the reject loop, with a registered result.
// ----------------------------------------------------------------------------
module mtbd_engine (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mtbd_pkg::mtbd_cmd_t    cmd,
	input  logic                   cmd_valid,
	output logic                   cmd_pop,
	output logic                   res_valid,
	input  logic                   res_ready,
	output logic [15:0]            res_data,
	output mtbd_pkg::mtbd_estat_t  estat
);
	import mtbd_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SEED  = 3'd1;
	localparam logic [2:0] ST_CHECK = 3'd2;
	localparam logic [2:0] ST_TW_LD = 3'd3;
	localparam logic [2:0] ST_TW_A  = 3'd4;
	localparam logic [2:0] ST_TW_B  = 3'd5;
	localparam logic [2:0] ST_DRAW  = 3'd6;

	logic [WORD_W-1:0]  mem [WORDS];
	logic [WORD_W-1:0]  rd0_q;
	logic [WORD_W-1:0]  rd1_q;

	logic [2:0]         state_q;
	logic [IDX_W-1:0]   idx_q;
	logic [ADDR_W-1:0]  k_q;
	logic [WORD_W-1:0]  seed_q;
	logic [WORD_W-1:0]  cur_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [LIMIT_W-1:0] mask_q;
	logic               draw_pend_q;
	logic               res_valid_q;
	logic [LIMIT_W-1:0] res_data_q;

	logic [ADDR_W-1:0]  ra0;
	logic [ADDR_W-1:0]  ra1;
	logic               we;
	logic [ADDR_W-1:0]  wa;
	logic [WORD_W-1:0]  wd;
	logic [ADDR_W-1:0]  k_nxt;
	logic [ADDR_W-1:0]  k_far;
	logic [WORD_W-1:0]  y_mix;
	logic [WORD_W-1:0]  twisted;
	logic [WORD_W-1:0]  tempered;
	logic [LIMIT_W-1:0] cand;

	assign cmd_pop   = (state_q == ST_IDLE) && cmd_valid && !res_valid_q;
	assign res_valid = res_valid_q;
	assign res_data  = res_data_q;
	assign estat.idx = idx_q;

	always_comb begin
		k_nxt    = (k_q == LAST) ? '0 : k_q + 1'b1;
		k_far    = (k_q < WRAP_M) ? k_q + SHIFT_M : k_q - WRAP_M;
		y_mix    = {cur_q[WORD_W-1], rd0_q[WORD_W-2:0]};
		twisted  = rd1_q ^ (y_mix >> 1) ^ (y_mix[0] ? TWIST_A : '0);
		tempered = mtbd_temper(rd0_q);
		cand     = tempered[LIMIT_W-1:0] & mask_q;

		ra0 = '0;
		ra1 = k_far;
		we  = 1'b0;
		wa  = k_q;
		wd  = twisted;
		case (state_q)
			ST_CHECK: begin
				ra0 = (idx_q >= WORDS) ? '0 : idx_q;
			end
			ST_TW_A: begin
				ra0 = k_nxt;
			end
			ST_SEED: begin
				we = 1'b1;
				wd = seed_q;
			end
			ST_TW_B: begin
				we = 1'b1;
			end
			default: begin
				ra0 = '0;
			end
		endcase
	end

	// word memory
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd0_q <= mem[ra0];
		rd1_q <= mem[ra1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= UNSEEDED;
			k_q         <= '0;
			draw_pend_q <= 1'b0;
			res_valid_q <= 1'b0;
			res_data_q  <= '0;
			seed_q      <= '0;
			cur_q       <= '0;
			limit_q     <= '0;
			mask_q      <= '0;
		end else begin
			if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_pop) begin
						limit_q <= cmd.limit;
						mask_q  <= cmd.mask;
						case (cmd.kind)
							KIND_SEED: begin
								seed_q      <= cmd.seed;
								k_q         <= '0;
								draw_pend_q <= 1'b0;
								state_q     <= ST_SEED;
							end
							KIND_DRAW: begin
								state_q <= ST_CHECK;
							end
							default: begin
								res_data_q  <= '0;
								res_valid_q <= 1'b1;
							end
						endcase
					end
				end
				ST_SEED: begin
					seed_q <= WORD_W'(seed_q * SEED_MULT);
					if (k_q == LAST) begin
						idx_q   <= WORDS;
						state_q <= draw_pend_q ? ST_CHECK : ST_IDLE;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_CHECK: begin
					if (idx_q == UNSEEDED) begin
						seed_q      <= DEFAULT_SEED;
						k_q         <= '0;
						draw_pend_q <= 1'b1;
						state_q     <= ST_SEED;
					end else if (idx_q == WORDS) begin
						k_q     <= '0;
						state_q <= ST_TW_LD;
					end else begin
						state_q <= ST_DRAW;
					end
				end
				ST_TW_LD: begin
					cur_q   <= rd0_q;
					state_q <= ST_TW_A;
				end
				ST_TW_A: begin
					state_q <= ST_TW_B;
				end
				ST_TW_B: begin
					cur_q <= rd0_q;
					if (k_q == LAST) begin
						idx_q   <= '0;
						state_q <= ST_CHECK;
					end else begin
						k_q     <= k_nxt;
						state_q <= ST_TW_A;
					end
				end
				ST_DRAW: begin
					idx_q <= idx_q + 1'b1;
					if (cand < limit_q) begin
						res_data_q  <= cand;
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end else begin
						state_q <= ST_CHECK;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### hw/rtl/mersenne_twister_bounded_draw.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mersenne_twister_bounded_draw
// MT19937 generator returning values below a per-item limit (zero for zero), with
// multiplicative seeding and rejection of masked words at or above the limit.
// ----------------------------------------------------------------------------
// latency path from input accept to the earliest result handshake: the queue, then
// CHECK and DRAW for a draw from a ready word, or IDLE alone for a zero limit; each
// rejected word adds another CHECK and DRAW; every 624 words the table is twisted
// in place, a load (TW_LD) and then TW_A and TW_B per word; a seed item fills the
// table word by word in SEED. The engine holds one item at a time behind a 2-entry
// queue and takes no new one while a result waits; reset spares the word table
module mersenne_twister_bounded_draw #(
	parameter int unsigned QUEUE_DEPTH = mtbd_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // seed_value[31:0], upper_limit[47:32]
	input  logic        s_tuser,   // func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // random_value[15:0]
);
	import mtbd_pkg::*;

	mtbd_qstat_t qstat;
	mtbd_estat_t estat;
	mtbd_cmd_t   push_cmd;
	mtbd_cmd_t   head_cmd;
	logic        push;
	logic        pop;

	mtbd_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.qstat    (qstat),
		.push     (push),
		.cmd      (push_cmd)
	);

	mtbd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.qstat    (qstat)
	);

	mtbd_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (head_cmd),
		.cmd_valid (!qstat.empty),
		.cmd_pop   (pop),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res_data  (m_tdata),
		.estat     (estat)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full)
		else $error("queue written while full");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("queue read while empty");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		estat.idx <= UNSEEDED)
		else $error("word index out of range");

	a_pop_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !m_tvalid)
		else $error("command taken while a result is pending");

endmodule

### tb/sv/mtbd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtbd_checker
// Watches both streams of the bounded draw twister. It keeps its own copy of
// the 624-word table and the read index, and works out the expected value
// for every accepted draw. Each returned item is compared in order against
// these values. Mismatches and unexpected items are counted.
// ----------------------------------------------------------------------------
module mtbd_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [47:0] s_tdata,   // seed_value[31:0], upper_limit[47:32]
	input  logic        s_tuser,   // func
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,   // random_value[15:0]
	output int          fail_count,
	output int          pending
);
	import mtbd_pkg::*;

	localparam logic [31:0] UPPER_BIT  = 32'h8000_0000;
	localparam logic [31:0] LOWER_BITS = 32'h7fff_ffff;

	logic [31:0] word_ram [0:623];
	logic [9:0]  word_pos;
	logic [15:0] expected_draws [$];

	function automatic void fill_words(input logic [31:0] seed);
		word_ram[0] = seed;
		for (int i = 1; i < WORDS; i++) begin
			word_ram[i] = word_ram[i-1] * SEED_MULT;
		end
		word_pos = WORDS;
	endfunction

	function automatic void twist_words();
		logic [31:0] y;
		for (int k = 0; k < WORDS; k++) begin
			y = (word_ram[k] & UPPER_BIT) | (word_ram[(k + 1) % WORDS] & LOWER_BITS);
			word_ram[k] = word_ram[(k + SHIFT_M) % WORDS] ^ (y >> 1)
				^ (y[0] ? TWIST_A : 32'h0);
		end
		word_pos = 10'd0;
	endfunction

	function automatic logic [31:0] next_word();
		logic [31:0] y;
		if (word_pos >= WORDS) begin
			// never seeded: fall back to the default seed
			if (word_pos != WORDS) begin
				fill_words(DEFAULT_SEED);
			end
			twist_words();
		end
		y = word_ram[word_pos];
		word_pos = word_pos + 10'd1;
		y ^= y >> 11;
		y ^= (y << 7) & TEMPER_B;
		y ^= (y << 15) & TEMPER_C;
		y ^= y >> 18;
		return y;
	endfunction

	function automatic logic [15:0] bounded_draw(input logic [15:0] limit);
		logic [15:0] mask;
		logic [15:0] t;
		logic [31:0] cand;
		// zero limit leaves the table and index alone
		if (limit == 16'd0) begin
			return 16'd0;
		end
		mask = 16'd0;
		for (t = limit; t != 16'd0; t = t >> 1) begin
			mask = {mask[14:0], 1'b1};
		end
		cand = next_word() & {16'd0, mask};
		while (cand >= {16'd0, limit}) begin
			cand = next_word() & {16'd0, mask};
		end
		return cand[15:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		logic [15:0] want;
		if (!arst_n) begin
			expected_draws.delete();
			word_pos = UNSEEDED;
			fail_count = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_draws.size() == 0) begin
					fail_count++;
					$display("%0t: random_value expected none, got %h", $time, m_tdata);
				end else begin
					want = expected_draws.pop_front();
					if (m_tdata !== want) begin
						fail_count++;
						$display("%0t: random_value expected %h, got %h", $time, want, m_tdata);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				if ({1'b0, s_tuser} == KIND_SEED) begin
					fill_words(s_tdata[31:0]);
				end else begin
					expected_draws.push_back(bounded_draw(s_tdata[47:32]));
				end
			end
		end
		pending = expected_draws.size();
	end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the bounded draw twister. Sends a directed set of
// seed and draw items, then random items in bursts, while the result side
// stalls on its own pattern with one long hold-off. The checker does the
// prediction and comparison.
// ----------------------------------------------------------------------------
module tb_top;
	import mtbd_pkg::*;

	typedef enum {READY_ALWAYS, READY_HALF, READY_SPARSE} stall_mode_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata  = '0;
	logic        s_tuser  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;

	int fail_count;
	int pending;
	int items_sent = 0;
	int burst_left = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	mersenne_twister_bounded_draw uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	mtbd_checker draw_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// called and returns at a falling edge
	task automatic put_item(input logic [1:0] kind, input logic [31:0] seed,
			input logic [15:0] limit);
		int gap;
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			gap = $urandom_range(1, 12);
			repeat (gap) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind[0];
		s_tdata  <= {limit, seed};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		items_sent++;
		burst_left--;
		@(negedge clk);
	endtask

	task automatic put_random_draw();
		int pick;
		int k;
		logic [15:0] limit;
		pick = $urandom_range(0, 99);
		k = $urandom_range(0, 15);
		if (pick < 6) begin
			limit = 16'd0;
		end else if (pick < 30) begin
			limit = 16'($urandom_range(1, 16));
		end else if (pick < 50) begin
			// just around powers of two
			limit = (16'd1 << k) + 16'($urandom_range(0, 2)) - 16'd1;
		end else begin
			limit = 16'($urandom_range(1, 65535));
		end
		put_item(KIND_DRAW, $urandom, limit);
	endtask

	initial begin
		stall_mode_t mode;
		int span;
		bit held_off;
		mode = READY_ALWAYS;
		span = 0;
		held_off = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held_off && items_sent >= 150) begin
				// long hold-off so the input side backs up
				held_off = 1'b1;
				m_tready <= 1'b0;
				repeat (300) @(negedge clk);
			end
			if (span == 0) begin
				mode = stall_mode_t'($urandom_range(0, 2));
				span = $urandom_range(10, 80);
			end
			span--;
			case (mode)
				READY_ALWAYS: m_tready <= 1'b1;
				READY_HALF:   m_tready <= 1'($urandom_range(0, 1));
				default:      m_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// unseeded: zero limit first, then the default seed kicks in
		put_item(KIND_DRAW, 32'hffff_ffff, 16'd0);
		put_item(KIND_DRAW, 32'h0, 16'd1);
		put_item(KIND_DRAW, 32'h0, 16'hffff);
		put_item(KIND_DRAW, 32'h0, 16'd2);
		put_item(KIND_DRAW, 32'h0, 16'h8000);
		put_item(KIND_DRAW, 32'h0, 16'h7fff);
		put_item(KIND_DRAW, 32'h0, 16'd3);
		put_item(KIND_DRAW, 32'h0, 16'd0);
		put_item(KIND_SEED, 32'h0, 16'hffff);
		put_item(KIND_DRAW, 32'hffff_ffff, 16'd1);
		put_item(KIND_DRAW, 32'h0, 16'hffff);
		put_item(KIND_SEED, 32'hffff_ffff, 16'h0);
		// zero limit right after a seed must not twist the table
		put_item(KIND_DRAW, 32'h0, 16'd0);
		put_item(KIND_DRAW, 32'h0, 16'hffff);
		put_item(KIND_DRAW, 32'h0, 16'd1);
		put_item(KIND_SEED, 32'h8000_0000, 16'h0);
		put_item(KIND_DRAW, 32'h0, 16'h8000);
		put_item(KIND_DRAW, 32'h0, 16'h8001);
		put_item(KIND_SEED, DEFAULT_SEED, 16'hffff);
		put_item(KIND_DRAW, 32'h0, 16'd1);
		put_item(KIND_DRAW, 32'h0, 16'hffff);
		put_item(KIND_DRAW, 32'h0, 16'hfffe);

		for (int i = 0; i < 700; i++) begin
			// no reseeding late on, so the index runs past the table end
			if (i < 200 && $urandom_range(0, 99) < 3) begin
				put_item(KIND_SEED, $urandom, 16'($urandom));
			end else begin
				put_random_draw();
			end
		end
		s_tvalid <= 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (1500) @(negedge clk);
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
